/* rtl/core/rrts_pkg.sv */
// Shared types, codes and constants of the round robin task scheduler.
package rrts_pkg;

    // Table geometry and timer scaling
    localparam int TASK_SLOTS  = 16;
    localparam int IDX_W       = $clog2(TASK_SLOTS);
    localparam int COUNT_W     = $clog2(TASK_SLOTS + 1);
    localparam int MS_PER_TICK = 10;

    // Reciprocal for ms / MS_PER_TICK, exact over 32-bit operands
    localparam int DIV_SHIFT = 32 + $clog2(MS_PER_TICK);
    localparam longint unsigned DIV_RECIP =
        ((64'd1 << DIV_SHIFT) + MS_PER_TICK - 1) / MS_PER_TICK;

    typedef enum logic [2:0] {
        ACT_INIT     = 3'd0,
        ACT_SPAWN    = 3'd1,
        ACT_SCHEDULE = 3'd2,
        ACT_TICK     = 3'd3,
        ACT_SLEEP    = 3'd4,
        ACT_EXIT     = 3'd5,
        ACT_KILL     = 3'd6,
        ACT_REAP     = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_NO_SLOT     = 3'd1,
        STAT_NOT_FOUND   = 3'd2,
        STAT_IDLE_PROT   = 3'd3,
        STAT_NOT_STARTED = 3'd4,
        STAT_NOTHING     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        SLOT_UNUSED   = 2'd0,
        SLOT_READY    = 2'd1,
        SLOT_SLEEPING = 2'd2,
        SLOT_DEAD     = 2'd3
    } slot_state_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] stack_pointer;
        logic [63:0] now;
        logic [31:0] sleep_ms;
        logic [31:0] target_id;
    } in_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] resume_sp;
        logic [31:0] task_id;
        logic [3:0]  slot;
        logic        switched;
        logic        killed_self;
        logic        last;
    } out_t;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NOP,
        OP_NOT_STARTED,
        OP_INIT,
        OP_SPAWN,
        OP_TICK,
        OP_EXIT,
        OP_SLEEP_DIV,
        OP_SLEEP_SET,
        OP_SCHED_SAVE,
        OP_WAKE,
        OP_PICK_START,
        OP_PICK,
        OP_SCHED_FIN,
        OP_KILL_START,
        OP_KILL,
        OP_REAP_START,
        OP_REAP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   accept;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    running;
        logic    done;
    } dp_stat_t;

endpackage

/* rtl/core/round_robin_task_scheduler.sv */
// Top level of the round robin task scheduler.
//
// Usage: drive request and raise start; the transaction is taken at a rising
// edge where start is high and busy is low. busy stays high until the last
// result of that transaction has been loaded into the result register.
// Each result appears on result for exactly one cycle with strobe high;
// the receiver cannot stall, so results are never held back.
// Steps: init, spawn, tick, exit and any action before init pass from
// dispatch through the one-shot state to their single result; sleep goes
// through the reciprocal multiply, then the wake tick update. Schedule
// walks the ring twice, one slot per cycle, up to TASK_SLOTS slots per
// pass, then finishes. Kill walks up to TASK_SLOTS slots; reap visits up
// to TASK_SLOTS slots plus a finishing step, issuing one result per freed
// slot as it goes. Only one transaction is in flight at a time.
// Reset clears the table and leaves the scheduler not started: every action
// other than init answers status not started.
module round_robin_task_scheduler
    import rrts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  request,
    output out_t result,
    output logic strobe
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rrts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    rrts_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .stat    (stat),
        .result  (result),
        .strobe  (strobe)
    );

endmodule

/* rtl/core/rrts_ctrl.sv */
// Controller state machine sequencing the scheduler datapath.
module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ONE_SHOT,
        S_SLEEP_DIV,
        S_SLEEP_SET,
        S_SCHED_SAVE,
        S_WAKE,
        S_PICK_START,
        S_PICK,
        S_SCHED_FIN,
        S_KILL_START,
        S_KILL,
        S_REAP_START,
        S_REAP
    } state_t;

    state_t state_reg;
    dp_op_t op_reg;

    assign busy       = (state_reg != S_IDLE);
    assign cmd.accept = start && (state_reg == S_IDLE);
    assign cmd.op     = op_reg;

    // State and registered command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_NOP;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    op_reg <= OP_NOP;
                    if (start)
                        state_reg <= S_DISPATCH;
                end
                S_DISPATCH:
                begin
                    if (!stat.running && stat.action != ACT_INIT)
                    begin
                        state_reg <= S_ONE_SHOT;
                        op_reg    <= OP_NOT_STARTED;
                    end
                    else
                    begin
                        unique case (stat.action)
                            ACT_INIT:
                            begin
                                state_reg <= S_ONE_SHOT;
                                op_reg    <= OP_INIT;
                            end
                            ACT_SPAWN:
                            begin
                                state_reg <= S_ONE_SHOT;
                                op_reg    <= OP_SPAWN;
                            end
                            ACT_TICK:
                            begin
                                state_reg <= S_ONE_SHOT;
                                op_reg    <= OP_TICK;
                            end
                            ACT_EXIT:
                            begin
                                state_reg <= S_ONE_SHOT;
                                op_reg    <= OP_EXIT;
                            end
                            ACT_SLEEP:
                            begin
                                state_reg <= S_SLEEP_DIV;
                                op_reg    <= OP_SLEEP_DIV;
                            end
                            ACT_SCHEDULE:
                            begin
                                state_reg <= S_SCHED_SAVE;
                                op_reg    <= OP_SCHED_SAVE;
                            end
                            ACT_KILL:
                            begin
                                state_reg <= S_KILL_START;
                                op_reg    <= OP_KILL_START;
                            end
                            ACT_REAP:
                            begin
                                state_reg <= S_REAP_START;
                                op_reg    <= OP_REAP_START;
                            end
                        endcase
                    end
                end
                S_ONE_SHOT:
                begin
                    state_reg <= S_IDLE;
                    op_reg    <= OP_NOP;
                end
                S_SLEEP_DIV:
                begin
                    state_reg <= S_SLEEP_SET;
                    op_reg    <= OP_SLEEP_SET;
                end
                S_SLEEP_SET:
                begin
                    state_reg <= S_IDLE;
                    op_reg    <= OP_NOP;
                end
                S_SCHED_SAVE:
                begin
                    state_reg <= S_WAKE;
                    op_reg    <= OP_WAKE;
                end
                S_WAKE:
                begin
                    if (stat.done)
                    begin
                        state_reg <= S_PICK_START;
                        op_reg    <= OP_PICK_START;
                    end
                end
                S_PICK_START:
                begin
                    state_reg <= S_PICK;
                    op_reg    <= OP_PICK;
                end
                S_PICK:
                begin
                    if (stat.done)
                    begin
                        state_reg <= S_SCHED_FIN;
                        op_reg    <= OP_SCHED_FIN;
                    end
                end
                S_SCHED_FIN:
                begin
                    state_reg <= S_IDLE;
                    op_reg    <= OP_NOP;
                end
                S_KILL_START:
                begin
                    state_reg <= S_KILL;
                    op_reg    <= OP_KILL;
                end
                S_KILL:
                begin
                    if (stat.done)
                    begin
                        state_reg <= S_IDLE;
                        op_reg    <= OP_NOP;
                    end
                end
                S_REAP_START:
                begin
                    state_reg <= S_REAP;
                    op_reg    <= OP_REAP;
                end
                S_REAP:
                begin
                    if (stat.done)
                    begin
                        state_reg <= S_IDLE;
                        op_reg    <= OP_NOP;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    op_reg    <= OP_NOP;
                end
            endcase
        end
    end

endmodule

/* rtl/core/rrts_datapath.sv */
// Task table, ring walker and result register of the scheduler.
module rrts_datapath
    import rrts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dp_cmd_t  cmd,
    input  in_t      request,
    output dp_stat_t stat,
    output out_t     result,
    output logic     strobe
);

    // Task table
    slot_state_t      state_reg  [TASK_SLOTS];
    slot_state_t      state_next [TASK_SLOTS];
    logic [IDX_W-1:0] succ_reg   [TASK_SLOTS];
    logic [IDX_W-1:0] succ_next  [TASK_SLOTS];
    logic [31:0]      ident_reg  [TASK_SLOTS];
    logic [31:0]      ident_next [TASK_SLOTS];
    logic [63:0]      wake_reg   [TASK_SLOTS];
    logic [63:0]      wake_next  [TASK_SLOTS];
    logic [31:0]      swc_reg    [TASK_SLOTS];
    logic [31:0]      swc_next   [TASK_SLOTS];
    logic [31:0]      ticks_reg  [TASK_SLOTS];
    logic [31:0]      ticks_next [TASK_SLOTS];
    logic [31:0]      sp_reg     [TASK_SLOTS];

    // Globals and walk registers
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [31:0]        last_id_reg, last_id_next;
    logic               running_reg, running_next;
    logic [IDX_W-1:0]   t_reg, t_next;
    logic [IDX_W-1:0]   start_reg, start_next;
    logic [IDX_W-1:0]   prev_reg, prev_next;
    logic [IDX_W-1:0]   nxt_reg, nxt_next;
    logic [IDX_W-1:0]   pend_reg, pend_next;
    logic               pend_vld_reg, pend_vld_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]        quot_reg, quot_next;
    in_t                in_reg;
    out_t               res_reg, res_next;
    logic               strobe_reg, strobe_next;

    // Saved stack pointer write port
    logic               sp_we;
    logic [IDX_W-1:0]   sp_waddr;
    logic [31:0]        sp_wdata;

    logic [IDX_W-1:0]   succ_t;
    logic [IDX_W-1:0]   succ_cur;
    logic               last_step;
    logic               done;
    logic [IDX_W-1:0]   free_idx;
    logic               free_found;
    logic [67:0]        div_prod;
    out_t               blank;

    assign succ_t    = succ_reg[t_reg];
    assign succ_cur  = succ_reg[cur_reg];
    assign last_step = (cnt_reg == COUNT_W'(TASK_SLOTS - 1));
    assign div_prod  = 68'(in_reg.sleep_ms) * 68'(DIV_RECIP);
    assign blank     = out_t'('0);

    // First unused slot
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int k = TASK_SLOTS - 1; k >= 0; k--)
        begin
            if (state_reg[k] == SLOT_UNUSED)
            begin
                free_idx   = IDX_W'(k);
                free_found = 1'b1;
            end
        end
    end

    // Operation logic
    always_comb
    begin
        state_next    = state_reg;
        succ_next     = succ_reg;
        ident_next    = ident_reg;
        wake_next     = wake_reg;
        swc_next      = swc_reg;
        ticks_next    = ticks_reg;
        cur_next      = cur_reg;
        last_id_next  = last_id_reg;
        running_next  = running_reg;
        t_next        = t_reg;
        start_next    = start_reg;
        prev_next     = prev_reg;
        nxt_next      = nxt_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        cnt_next      = cnt_reg;
        quot_next     = quot_reg;
        res_next      = res_reg;
        strobe_next   = 1'b0;
        sp_we         = 1'b0;
        sp_waddr      = cur_reg;
        sp_wdata      = in_reg.stack_pointer;
        done          = 1'b0;

        unique case (cmd.op)
            OP_NOP:
            begin
            end
            OP_NOT_STARTED:
            begin
                res_next        = blank;
                res_next.status = STAT_NOT_STARTED;
                if (in_reg.action == ACT_SCHEDULE)
                    res_next.resume_sp = in_reg.stack_pointer;
                res_next.last   = 1'b1;
                strobe_next     = 1'b1;
            end
            OP_INIT:
            begin
                for (int k = 0; k < TASK_SLOTS; k++)
                begin
                    state_next[k] = SLOT_UNUSED;
                    succ_next[k]  = '0;
                    ident_next[k] = '0;
                    wake_next[k]  = '0;
                    swc_next[k]   = '0;
                    ticks_next[k] = '0;
                end
                state_next[0] = SLOT_READY;
                cur_next      = '0;
                running_next  = 1'b1;
                res_next      = blank;
                res_next.last = 1'b1;
                strobe_next   = 1'b1;
            end
            OP_SPAWN:
            begin
                res_next      = blank;
                res_next.last = 1'b1;
                strobe_next   = 1'b1;
                if (!free_found)
                    res_next.status = STAT_NO_SLOT;
                else
                begin
                    last_id_next         = last_id_reg + 32'd1;
                    ident_next[free_idx] = last_id_reg + 32'd1;
                    state_next[free_idx] = SLOT_READY;
                    wake_next[free_idx]  = '0;
                    swc_next[free_idx]   = '0;
                    ticks_next[free_idx] = '0;
                    sp_we                = 1'b1;
                    sp_waddr             = free_idx;
                    succ_next[free_idx]  = succ_cur;
                    succ_next[cur_reg]   = free_idx;
                    res_next.task_id     = last_id_reg + 32'd1;
                    res_next.slot        = 4'(free_idx);
                end
            end
            OP_TICK:
            begin
                ticks_next[cur_reg] = ticks_reg[cur_reg] + 32'd1;
                res_next            = blank;
                res_next.last       = 1'b1;
                strobe_next         = 1'b1;
            end
            OP_EXIT:
            begin
                res_next      = blank;
                res_next.last = 1'b1;
                strobe_next   = 1'b1;
                if (cur_reg == '0)
                    res_next.status = STAT_IDLE_PROT;
                else
                    state_next[cur_reg] = SLOT_DEAD;
            end
            OP_SLEEP_DIV:
            begin
                quot_next = div_prod[DIV_SHIFT +: 32];
            end
            OP_SLEEP_SET:
            begin
                wake_next[cur_reg]  = in_reg.now + 64'(quot_reg);
                state_next[cur_reg] = SLOT_SLEEPING;
                res_next            = blank;
                res_next.last       = 1'b1;
                strobe_next         = 1'b1;
            end
            OP_SCHED_SAVE:
            begin
                sp_we    = 1'b1;
                t_next   = cur_reg;
                cnt_next = '0;
            end
            OP_WAKE:
            begin
                if (state_reg[t_reg] == SLOT_SLEEPING && in_reg.now >= wake_reg[t_reg])
                    state_next[t_reg] = SLOT_READY;
                done     = (succ_t == cur_reg) || last_step;
                t_next   = succ_t;
                cnt_next = cnt_reg + COUNT_W'(1);
            end
            OP_PICK_START:
            begin
                t_next     = succ_cur;
                start_next = succ_cur;
                cnt_next   = '0;
                nxt_next   = '0;
            end
            OP_PICK:
            begin
                if (t_reg != '0 && state_reg[t_reg] == SLOT_READY)
                begin
                    nxt_next = t_reg;
                    done     = 1'b1;
                end
                else
                begin
                    done     = (succ_t == start_reg) || last_step;
                    t_next   = succ_t;
                    cnt_next = cnt_reg + COUNT_W'(1);
                end
            end
            OP_SCHED_FIN:
            begin
                res_next      = blank;
                res_next.last = 1'b1;
                strobe_next   = 1'b1;
                if (nxt_reg == cur_reg)
                begin
                    res_next.resume_sp = in_reg.stack_pointer;
                    res_next.slot      = 4'(cur_reg);
                end
                else
                begin
                    swc_next[nxt_reg]  = swc_reg[nxt_reg] + 32'd1;
                    cur_next           = nxt_reg;
                    res_next.resume_sp = sp_reg[nxt_reg];
                    res_next.slot      = 4'(nxt_reg);
                    res_next.switched  = 1'b1;
                end
            end
            OP_KILL_START:
            begin
                t_next   = cur_reg;
                cnt_next = '0;
            end
            OP_KILL:
            begin
                if (ident_reg[t_reg] == in_reg.target_id &&
                    (state_reg[t_reg] == SLOT_READY || state_reg[t_reg] == SLOT_SLEEPING))
                begin
                    done          = 1'b1;
                    res_next      = blank;
                    res_next.last = 1'b1;
                    strobe_next   = 1'b1;
                    if (t_reg == '0)
                        res_next.status = STAT_IDLE_PROT;
                    else
                    begin
                        state_next[t_reg]    = SLOT_DEAD;
                        res_next.killed_self = (t_reg == cur_reg);
                    end
                end
                else
                begin
                    t_next   = succ_t;
                    cnt_next = cnt_reg + COUNT_W'(1);
                    if (succ_t == cur_reg || last_step)
                    begin
                        done            = 1'b1;
                        res_next        = blank;
                        res_next.status = STAT_NOT_FOUND;
                        res_next.last   = 1'b1;
                        strobe_next     = 1'b1;
                    end
                end
            end
            OP_REAP_START:
            begin
                prev_next     = cur_reg;
                t_next        = succ_cur;
                cnt_next      = '0;
                pend_vld_next = 1'b0;
            end
            OP_REAP:
            begin
                if (cnt_reg == COUNT_W'(TASK_SLOTS) || t_reg == cur_reg)
                begin
                    // End of the ring: flush the held slot as the final one
                    done          = 1'b1;
                    res_next      = blank;
                    res_next.last = 1'b1;
                    strobe_next   = 1'b1;
                    if (pend_vld_reg)
                        res_next.slot = 4'(pend_reg);
                    else
                        res_next.status = STAT_NOTHING;
                end
                else
                begin
                    if (state_reg[t_reg] == SLOT_DEAD)
                    begin
                        succ_next[prev_reg] = succ_t;
                        succ_next[t_reg]    = '0;
                        state_next[t_reg]   = SLOT_UNUSED;
                        if (pend_vld_reg)
                        begin
                            res_next      = blank;
                            res_next.slot = 4'(pend_reg);
                            strobe_next   = 1'b1;
                        end
                        pend_next     = t_reg;
                        pend_vld_next = 1'b1;
                    end
                    else
                        prev_next = t_reg;
                    t_next   = succ_t;
                    cnt_next = cnt_reg + COUNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control and table registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TASK_SLOTS; k++)
            begin
                state_reg[k] <= SLOT_UNUSED;
                succ_reg[k]  <= '0;
                ident_reg[k] <= '0;
                wake_reg[k]  <= '0;
                swc_reg[k]   <= '0;
                ticks_reg[k] <= '0;
            end
            cur_reg      <= '0;
            last_id_reg  <= '0;
            running_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            cnt_reg      <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            succ_reg     <= succ_next;
            ident_reg    <= ident_next;
            wake_reg     <= wake_next;
            swc_reg      <= swc_next;
            ticks_reg    <= ticks_next;
            cur_reg      <= cur_next;
            last_id_reg  <= last_id_next;
            running_reg  <= running_next;
            pend_vld_reg <= pend_vld_next;
            cnt_reg      <= cnt_next;
            strobe_reg   <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        start_reg <= start_next;
        prev_reg  <= prev_next;
        nxt_reg   <= nxt_next;
        pend_reg  <= pend_next;
        quot_reg  <= quot_next;
        res_reg   <= res_next;
        if (cmd.accept)
            in_reg <= request;
        if (sp_we)
            sp_reg[sp_waddr] <= sp_wdata;
    end

    assign stat.action  = in_reg.action;
    assign stat.running = running_reg;
    assign stat.done    = done;
    assign result       = res_reg;
    assign strobe       = strobe_reg;

endmodule

/* dv/testbench.sv */
// Testbench for the round robin task scheduler: task-table predictor, random traffic, result checks.
`timescale 1ns / 100ps

module testbench;
    import rrts_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  request;
    out_t result;
    logic strobe;

    round_robin_task_scheduler dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .result  (result),
        .strobe  (strobe)
    );

    // Predictor copy of the task table
    slot_state_t      tbl_state [TASK_SLOTS];
    logic [3:0]       tbl_next  [TASK_SLOTS];
    logic [31:0]      tbl_ident [TASK_SLOTS];
    logic [63:0]      tbl_wake  [TASK_SLOTS];
    logic [31:0]      tbl_sp    [TASK_SLOTS];
    logic [31:0]      tbl_swcnt [TASK_SLOTS];
    logic [31:0]      tbl_ticks [TASK_SLOTS];
    logic [3:0]       cur_slot;
    logic [31:0]      ident_ctr;
    logic             started;

    in_t  pending_items [$];
    out_t expected_results [$];
    int   error_count;
    int   cycle_count;
    bit   stim_done;
    bit   no_idle;

    localparam int CYCLE_LIMIT = 400000;

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic out_t mk_result(status_t st, logic [31:0] rsp, logic [31:0] id,
                                       logic [3:0] sl, logic sw, logic ks, logic lst);
        out_t r;
        r.status = st; r.resume_sp = rsp; r.task_id = id; r.slot = sl;
        r.switched = sw; r.killed_self = ks; r.last = lst;
        return r;
    endfunction

    function automatic void clear_tables();
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            tbl_state[i] = SLOT_UNUSED; tbl_next[i] = '0; tbl_ident[i] = '0;
            tbl_wake[i] = '0; tbl_sp[i] = '0; tbl_swcnt[i] = '0; tbl_ticks[i] = '0;
        end
    endfunction

    // Advance the scheduler model by one transaction, queueing expected results
    function automatic void predict_scheduler(in_t it);
        logic [3:0] c, t, strt, nxt, prev, nx;
        int n;
        bit found;
        c = cur_slot;
        if (it.action == ACT_INIT)
        begin
            clear_tables();
            tbl_state[0] = SLOT_READY;
            cur_slot = 0;
            started = 1;
            expected_results.push_back(mk_result(STAT_OK, 0, 0, 0, 0, 0, 1));
            return;
        end
        if (!started)
        begin
            expected_results.push_back(mk_result(STAT_NOT_STARTED,
                it.action == ACT_SCHEDULE ? it.stack_pointer : 32'd0, 0, 0, 0, 0, 1));
            return;
        end
        case (it.action)
            ACT_SPAWN:
            begin
                found = 0;
                for (int i = 0; i < TASK_SLOTS && !found; i++)
                    if (tbl_state[i] == SLOT_UNUSED)
                    begin
                        t = i[3:0]; found = 1;
                    end
                if (!found)
                    expected_results.push_back(mk_result(STAT_NO_SLOT, 0, 0, 0, 0, 0, 1));
                else
                begin
                    ident_ctr++;
                    tbl_ident[t] = ident_ctr; tbl_state[t] = SLOT_READY;
                    tbl_wake[t] = 0; tbl_swcnt[t] = 0; tbl_ticks[t] = 0;
                    tbl_sp[t] = it.stack_pointer;
                    tbl_next[t] = tbl_next[c];
                    tbl_next[c] = t;
                    expected_results.push_back(mk_result(STAT_OK, 0, ident_ctr, t, 0, 0, 1));
                end
            end
            ACT_SCHEDULE:
            begin
                tbl_sp[c] = it.stack_pointer;
                t = c;
                for (int i = 0; i < TASK_SLOTS; i++)
                begin
                    if (tbl_state[t] == SLOT_SLEEPING && it.now >= tbl_wake[t])
                        tbl_state[t] = SLOT_READY;
                    t = tbl_next[t];
                    if (t == c)
                        break;
                end
                strt = tbl_next[c];
                t = strt;
                nxt = 0;
                for (int i = 0; i < TASK_SLOTS; i++)
                begin
                    if (t != 0 && tbl_state[t] == SLOT_READY)
                    begin
                        nxt = t;
                        break;
                    end
                    t = tbl_next[t];
                    if (t == strt)
                        break;
                end
                if (nxt == c)
                    expected_results.push_back(mk_result(STAT_OK, it.stack_pointer, 0, c,
                                                         0, 0, 1));
                else
                begin
                    tbl_swcnt[nxt]++;
                    cur_slot = nxt;
                    expected_results.push_back(mk_result(STAT_OK, tbl_sp[nxt], 0, nxt,
                                                         1, 0, 1));
                end
            end
            ACT_TICK:
            begin
                tbl_ticks[c]++;
                expected_results.push_back(mk_result(STAT_OK, 0, 0, 0, 0, 0, 1));
            end
            ACT_SLEEP:
            begin
                tbl_wake[c] = it.now + 64'(it.sleep_ms / MS_PER_TICK);
                tbl_state[c] = SLOT_SLEEPING;
                expected_results.push_back(mk_result(STAT_OK, 0, 0, 0, 0, 0, 1));
            end
            ACT_EXIT:
            begin
                if (c == 0)
                    expected_results.push_back(mk_result(STAT_IDLE_PROT, 0, 0, 0, 0, 0, 1));
                else
                begin
                    tbl_state[c] = SLOT_DEAD;
                    expected_results.push_back(mk_result(STAT_OK, 0, 0, 0, 0, 0, 1));
                end
            end
            ACT_KILL:
            begin
                t = c;
                found = 0;
                for (int i = 0; i < TASK_SLOTS; i++)
                begin
                    if (tbl_ident[t] == it.target_id &&
                        (tbl_state[t] == SLOT_READY || tbl_state[t] == SLOT_SLEEPING))
                    begin
                        found = 1;
                        if (t == 0)
                            expected_results.push_back(mk_result(STAT_IDLE_PROT, 0, 0, 0,
                                                                 0, 0, 1));
                        else
                        begin
                            tbl_state[t] = SLOT_DEAD;
                            expected_results.push_back(mk_result(STAT_OK, 0, 0, 0, 0,
                                                                 t == c, 1));
                        end
                        break;
                    end
                    t = tbl_next[t];
                    if (t == c)
                        break;
                end
                if (!found)
                    expected_results.push_back(mk_result(STAT_NOT_FOUND, 0, 0, 0, 0, 0, 1));
            end
            default:
            begin
                // Reap: unlink dead slots, one result per freed slot
                n = 0;
                prev = c;
                t = tbl_next[c];
                for (int i = 0; i < TASK_SLOTS && t != c; i++)
                begin
                    nx = tbl_next[t];
                    if (tbl_state[t] == SLOT_DEAD)
                    begin
                        tbl_next[prev] = nx;
                        tbl_next[t] = 0;
                        tbl_state[t] = SLOT_UNUSED;
                        expected_results.push_back(mk_result(STAT_OK, 0, 0, t, 0, 0, 0));
                        n++;
                    end
                    else
                        prev = t;
                    t = nx;
                end
                if (n == 0)
                    expected_results.push_back(mk_result(STAT_NOTHING, 0, 0, 0, 0, 0, 1));
                else
                    expected_results[$].last = 1;
            end
        endcase
    endfunction

    function automatic in_t make_item(action_t a);
        in_t it;
        it.action = a;
        it.stack_pointer = $urandom;
        it.now = {$urandom, $urandom};
        it.sleep_ms = $urandom;
        it.target_id = $urandom;
        return it;
    endfunction

    // Likely-live identifier for kill targets, near the recent spawn count
    function automatic logic [31:0] ident_ctr_guess(int k);
        return $urandom_range(0, 16 + k / 4);
    endfunction

    // Stimulus: directed corner cases, then weighted random traffic
    initial
    begin
        in_t it;
        int pick;
        logic [63:0] clock_now;
        clk = 0; rst_n = 0; start = 0; request = '0;
        error_count = 0; cycle_count = 0; stim_done = 0; no_idle = 0;
        clear_tables();
        cur_slot = 0; ident_ctr = 0; started = 0;

        // Before init every action answers not started
        for (int a = 1; a < 8; a++)
            pending_items.push_back(make_item(action_t'(a)));
        pending_items.push_back(make_item(ACT_INIT));
        pending_items.push_back(make_item(ACT_EXIT));
        pending_items.push_back(make_item(ACT_REAP));
        it = make_item(ACT_KILL); it.target_id = 0;
        pending_items.push_back(it);
        for (int i = 0; i < 16; i++)
        begin
            it = make_item(ACT_SPAWN);
            it.stack_pointer = (i == 0) ? 32'hFFFF_FFFF : (i == 1 ? 32'h0 : $urandom);
            pending_items.push_back(it);
        end
        it = make_item(ACT_SLEEP); it.now = 64'hFFFF_FFFF_FFFF_FFF0;
        it.sleep_ms = 32'hFFFF_FFFF;
        pending_items.push_back(it);
        it = make_item(ACT_SCHEDULE); it.now = 0;
        pending_items.push_back(it);

        clock_now = 0;
        for (int k = 0; k < 105; k++)
        begin
            pick = $urandom_range(0, 99);
            clock_now += $urandom_range(0, 5);
            if (pick < 3)
                it = make_item(ACT_INIT);
            else if (pick < 20)
                it = make_item(ACT_SPAWN);
            else if (pick < 50)
                it = make_item(ACT_SCHEDULE);
            else if (pick < 58)
                it = make_item(ACT_TICK);
            else if (pick < 68)
                it = make_item(ACT_SLEEP);
            else if (pick < 76)
                it = make_item(ACT_EXIT);
            else if (pick < 88)
                it = make_item(ACT_KILL);
            else
                it = make_item(ACT_REAP);
            if (it.action == ACT_SCHEDULE || it.action == ACT_SLEEP)
            begin
                if ($urandom_range(0, 9) != 0)
                    it.now = clock_now;
                if ($urandom_range(0, 3) != 0)
                    it.sleep_ms = $urandom_range(0, 60);
            end
            if (it.action == ACT_KILL && $urandom_range(0, 4) != 0)
                it.target_id = ident_ctr_guess(k);
            pending_items.push_back(it);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1;
    end

    // Driver: present queued transactions, idle at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            no_idle <= (cycle_count > 200 && cycle_count < 600);
            if (start && !busy)
            begin
                predict_scheduler(request);
                void'(pending_items.pop_front());
            end
            if ((start && !busy) || !start)
            begin
                if (pending_items.size() > 0 &&
                    (no_idle || $urandom_range(0, 99) >= 25))
                begin
                    start <= 1;
                    request <= pending_items[0];
                end
                else
                    start <= 0;
            end
            if (pending_items.size() == 0 && !(start && busy))
                stim_done <= 1;
        end
    end

    // Monitor: compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin
        out_t exp_r;
        if (rst_n && strobe)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                exp_r = expected_results.pop_front();
                if (result.status !== exp_r.status)
                    report_mismatch($sformatf("status %0d exp %0d", result.status,
                                              exp_r.status));
                if (result.resume_sp !== exp_r.resume_sp)
                    report_mismatch($sformatf("resume_sp %h exp %h", result.resume_sp,
                                              exp_r.resume_sp));
                if (result.task_id !== exp_r.task_id)
                    report_mismatch($sformatf("task_id %0d exp %0d", result.task_id,
                                              exp_r.task_id));
                if (result.slot !== exp_r.slot)
                    report_mismatch($sformatf("slot %0d exp %0d", result.slot, exp_r.slot));
                if (result.switched !== exp_r.switched)
                    report_mismatch("switched differs");
                if (result.killed_self !== exp_r.killed_self)
                    report_mismatch("killed_self differs");
                if (result.last !== exp_r.last)
                    report_mismatch("last differs");
            end
        end
    end

    // End of run and timeout
    initial
    begin
        wait (rst_n);
        wait ((stim_done && expected_results.size() == 0) || cycle_count >= CYCLE_LIMIT);
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** round_robin_task_scheduler: FAILED **");
            $finish;
        end
        else
        begin
            repeat (50) @(posedge clk);
            if (error_count == 0)
                $display("** round_robin_task_scheduler: PASSED **");
            else
                $display("** round_robin_task_scheduler: FAILED **");
            $finish;
        end
    end

endmodule
